FILE: rtl/mtpu_pkg.sv
// Shared types and constants for the memory test pattern unit.
package mtpu_pkg;

    typedef logic [3:0] action_t;

    localparam action_t ACT_STUCK  = 4'd0;
    localparam action_t ACT_RANDOM = 4'd1;
    localparam action_t ACT_XOR    = 4'd2;
    localparam action_t ACT_SUB    = 4'd3;
    localparam action_t ACT_MUL    = 4'd4;
    localparam action_t ACT_DIV    = 4'd5;
    localparam action_t ACT_OR     = 4'd6;
    localparam action_t ACT_AND    = 4'd7;
    localparam action_t ACT_SEQINC = 4'd8;
    localparam action_t ACT_SOLID  = 4'd9;
    localparam action_t ACT_CHECK  = 4'd10;
    localparam action_t ACT_BLOCK  = 4'd11;
    localparam action_t ACT_WALK0  = 4'd12;
    localparam action_t ACT_WALK1  = 4'd13;
    localparam action_t ACT_SPREAD = 4'd14;
    localparam action_t ACT_FLIP   = 4'd15;

    localparam int IN_DATA_BITS  = 360;
    localparam int OUT_DATA_BITS = 136;

    localparam logic [63:0] CHECK_EVEN = {32{2'b01}};
    localparam logic [63:0] CHECK_ODD  = {32{2'b10}};

    typedef struct packed {
        action_t     action;
        logic [8:0]  pass_number;
        logic [19:0] word_index;
        logic [63:0] word_address;
        logic [63:0] seed_word;
        logic [63:0] old_word;
    } item_t;

endpackage

FILE: rtl/mtpu_delay.sv
// Enabled shift-register delay line.
module mtpu_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] stage_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= din;
            for (int n = 1; n < DEPTH; n++)
            begin
                stage_reg[n] <= stage_reg[n-1];
            end
        end
    end

    assign dout = stage_reg[DEPTH-1];

endmodule

FILE: rtl/mtpu_pattern.sv
// Two-stage generator for all pattern words except multiply and divide.
module mtpu_pattern import mtpu_pkg::*; #(
    parameter int WORD_BITS = 64
) (
    input  logic                 clk,
    input  logic                 en,
    input  item_t                item,
    output logic [WORD_BITS-1:0] pattern
);

    localparam int M2     = 2 * WORD_BITS;
    localparam int RSH    = 20;
    localparam int RECIP2 = (1 << RSH) / M2;
    localparam int RECIPW = (1 << RSH) / WORD_BITS;

    logic [29:0] prod2;
    logic [9:0]  quo2;
    logic [16:0] rem2;
    logic [16:0] jval;
    logic [7:0]  pos_next;
    logic [29:0] prodw;
    logic [9:0]  quow;
    logic [16:0] remw;
    logic [16:0] kval;

    action_t              act_reg;
    logic                 p0_reg;
    logic [7:0]           pbyte_reg;
    logic [19:0]          idx_reg;
    logic [WORD_BITS-1:0] addr_reg;
    logic [WORD_BITS-1:0] seed_reg;
    logic [WORD_BITS-1:0] old_reg;
    logic [7:0]           pos_reg;
    logic [6:0]           k_reg;

    logic [WORD_BITS-1:0] one;
    logic [WORD_BITS-1:0] bit_pos;
    logic [WORD_BITS-1:0] bit_pos2;
    logic [WORD_BITS-1:0] bit_k;
    logic [WORD_BITS-1:0] base;
    logic [WORD_BITS-1:0] flip_t;
    logic [63:0]          sum64;
    logic [63:0]          rep64;
    logic [WORD_BITS-1:0] pattern_next;
    logic [WORD_BITS-1:0] pattern_reg;

    always_comb
    begin
        prod2 = 30'(item.pass_number) * 30'(RECIP2);
        quo2  = prod2[29:RSH];
        rem2  = 17'(item.pass_number) - 17'(quo2) * 17'(M2);
        jval  = (rem2 >= 17'(M2)) ? rem2 - 17'(M2) : rem2;
        pos_next = (jval < 17'(WORD_BITS)) ? jval[7:0] : 8'(M2 - 1) - jval[7:0];
        prodw = 30'(item.pass_number[8:3]) * 30'(RECIPW);
        quow  = prodw[29:RSH];
        remw  = 17'(item.pass_number[8:3]) - 17'(quow) * 17'(WORD_BITS);
        kval  = (remw >= 17'(WORD_BITS)) ? remw - 17'(WORD_BITS) : remw;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            act_reg   <= item.action;
            p0_reg    <= item.pass_number[0];
            pbyte_reg <= item.pass_number[7:0];
            idx_reg   <= item.word_index;
            addr_reg  <= item.word_address[WORD_BITS-1:0];
            seed_reg  <= item.seed_word[WORD_BITS-1:0];
            old_reg   <= item.old_word[WORD_BITS-1:0];
            pos_reg   <= pos_next;
            k_reg     <= kval[6:0];
        end
    end

    always_comb
    begin
        one      = {{(WORD_BITS-1){1'b0}}, 1'b1};
        bit_pos  = one << pos_reg;
        bit_pos2 = one << (9'(pos_reg) + 9'd2);
        bit_k    = one << k_reg;
        base     = '0;
        flip_t   = p0_reg ? bit_k : ~bit_k;
        sum64    = 64'(idx_reg) + 64'(seed_reg);
        rep64    = {8{pbyte_reg}};
        case (act_reg)
            ACT_STUCK:  pattern_next = (p0_reg ^ idx_reg[0]) ? ~addr_reg : addr_reg;
            ACT_RANDOM: pattern_next = seed_reg;
            ACT_XOR:    pattern_next = old_reg ^ seed_reg;
            ACT_SUB:    pattern_next = old_reg - seed_reg;
            ACT_OR:     pattern_next = old_reg | seed_reg;
            ACT_AND:    pattern_next = old_reg & seed_reg;
            ACT_SEQINC: pattern_next = sum64[WORD_BITS-1:0];
            ACT_SOLID:
            begin
                base = p0_reg ? '0 : '1;
                pattern_next = idx_reg[0] ? ~base : base;
            end
            ACT_CHECK:
            begin
                base = p0_reg ? CHECK_ODD[WORD_BITS-1:0] : CHECK_EVEN[WORD_BITS-1:0];
                pattern_next = idx_reg[0] ? ~base : base;
            end
            ACT_BLOCK:  pattern_next = rep64[WORD_BITS-1:0];
            ACT_WALK0:  pattern_next = bit_pos;
            ACT_WALK1:  pattern_next = ~bit_pos;
            ACT_SPREAD:
            begin
                base = bit_pos | bit_pos2;
                pattern_next = idx_reg[0] ? ~base : base;
            end
            ACT_FLIP:   pattern_next = idx_reg[0] ? ~flip_t : flip_t;
            default:    pattern_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pattern_reg <= pattern_next;
        end
    end

    assign pattern = pattern_reg;

endmodule

FILE: rtl/mtpu_mul.sv
// Two-stage low-half multiplier from 32x32 partial products.
module mtpu_mul #(
    parameter int WORD_BITS = 64
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [WORD_BITS-1:0] a,
    input  logic [WORD_BITS-1:0] b,
    output logic [WORD_BITS-1:0] product
);

    logic [63:0] a64;
    logic [63:0] b64;
    logic [63:0] ll_reg;
    logic [63:0] lh_reg;
    logic [63:0] hl_reg;
    logic [31:0] mid;
    logic [63:0] sum_next;
    logic [WORD_BITS-1:0] product_reg;

    assign a64 = 64'(a);
    assign b64 = 64'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= 64'(a64[31:0]) * 64'(b64[31:0]);
            lh_reg <= 64'(a64[31:0]) * 64'(b64[63:32]);
            hl_reg <= 64'(a64[63:32]) * 64'(b64[31:0]);
        end
    end

    always_comb
    begin
        mid      = lh_reg[31:0] + hl_reg[31:0];
        sum_next = ll_reg + {mid, 32'd0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= sum_next[WORD_BITS-1:0];
        end
    end

    assign product = product_reg;

endmodule

FILE: rtl/mtpu_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module mtpu_div #(
    parameter int WORD_BITS = 64
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [WORD_BITS-1:0] dividend,
    input  logic [WORD_BITS-1:0] divisor,
    output logic [WORD_BITS-1:0] quotient
);

    logic [WORD_BITS-1:0] rem_reg [1:WORD_BITS];
    logic [WORD_BITS-1:0] num_reg [1:WORD_BITS];
    logic [WORD_BITS-1:0] den_reg [1:WORD_BITS];

    for (genvar s = 0; s < WORD_BITS; s++)
    begin : g_stage
        logic [WORD_BITS-1:0] rem_in;
        logic [WORD_BITS-1:0] num_in;
        logic [WORD_BITS-1:0] den_in;
        logic [WORD_BITS:0]   trial;
        logic [WORD_BITS:0]   diff;
        logic                 take;

        if (s == 0)
        begin : g_first
            assign rem_in = '0;
            assign num_in = dividend;
            assign den_in = (divisor == '0) ? {{(WORD_BITS-1){1'b0}}, 1'b1} : divisor;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s];
            assign num_in = num_reg[s];
            assign den_in = den_reg[s];
        end

        always_comb
        begin
            trial = {rem_in, num_in[WORD_BITS-1]};
            diff  = trial - {1'b0, den_in};
            take  = (trial >= {1'b0, den_in});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= take ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
                num_reg[s+1] <= {num_in[WORD_BITS-2:0], take};
                den_reg[s+1] <= den_in;
            end
        end
    end

    assign quotient = num_reg[WORD_BITS];

endmodule

FILE: rtl/memory_test_pattern_unit.sv
// Top level of the memory test pattern and compare pipeline.
//
//  channel  | dir | fields (low bit up)
//  s_axis   | in  | action, pass_number, word_index, word_address, seed_word,
//           |     | old_word, read_a, read_b
//  m_axis   | out | pattern_word, mismatch, error_bits
//
// One request enters per cycle while the output is not stalled; each result passes through
// the input register, the divider stages (one quotient bit per stage) and the output register.
// Reset clears all valid bits; payload registers are not reset.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module memory_test_pattern_unit import mtpu_pkg::*; #(
    parameter int WORD_BITS = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // action, pass_number, word_index, word_address, seed_word, old_word, read_a, read_b
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // pattern_word, mismatch, error_bits
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

    logic                 adv;
    logic [WORD_BITS:0]   vld_reg;
    logic                 out_vld_reg;
    item_t                item_reg;
    logic [WORD_BITS-1:0] diff_reg;
    logic [WORD_BITS-1:0] pat_s2;
    logic [WORD_BITS-1:0] mul_s2;
    logic [WORD_BITS-1:0] pat_d;
    logic [WORD_BITS-1:0] mul_d;
    logic [WORD_BITS-1:0] div_d;
    logic [WORD_BITS-1:0] diff_d;
    action_t              act_d;
    logic [WORD_BITS-1:0] sel_next;
    logic [63:0]          pattern_reg;
    logic [63:0]          error_reg;
    logic                 mismatch_reg;

    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[WORD_BITS-1:0], s_axis_tvalid};
            out_vld_reg <= vld_reg[WORD_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg.action       <= s_axis_tdata[3:0];
            item_reg.pass_number  <= s_axis_tdata[12:4];
            item_reg.word_index   <= s_axis_tdata[32:13];
            item_reg.word_address <= s_axis_tdata[96:33];
            item_reg.seed_word    <= s_axis_tdata[160:97];
            item_reg.old_word     <= s_axis_tdata[224:161];
            diff_reg <= s_axis_tdata[225 +: WORD_BITS] ^ s_axis_tdata[289 +: WORD_BITS];
        end
    end

    mtpu_pattern #(.WORD_BITS(WORD_BITS)) u_pattern (
        .clk     (clk),
        .en      (adv),
        .item    (item_reg),
        .pattern (pat_s2)
    );

    mtpu_mul #(.WORD_BITS(WORD_BITS)) u_mul (
        .clk     (clk),
        .en      (adv),
        .a       (item_reg.old_word[WORD_BITS-1:0]),
        .b       (item_reg.seed_word[WORD_BITS-1:0]),
        .product (mul_s2)
    );

    mtpu_div #(.WORD_BITS(WORD_BITS)) u_div (
        .clk      (clk),
        .en       (adv),
        .dividend (item_reg.old_word[WORD_BITS-1:0]),
        .divisor  (item_reg.seed_word[WORD_BITS-1:0]),
        .quotient (div_d)
    );

    mtpu_delay #(.WIDTH(WORD_BITS), .DEPTH(WORD_BITS - 2)) u_pat_dly (
        .clk (clk), .en (adv), .din (pat_s2), .dout (pat_d)
    );

    mtpu_delay #(.WIDTH(WORD_BITS), .DEPTH(WORD_BITS - 2)) u_mul_dly (
        .clk (clk), .en (adv), .din (mul_s2), .dout (mul_d)
    );

    mtpu_delay #(.WIDTH(WORD_BITS), .DEPTH(WORD_BITS)) u_diff_dly (
        .clk (clk), .en (adv), .din (diff_reg), .dout (diff_d)
    );

    mtpu_delay #(.WIDTH(4), .DEPTH(WORD_BITS)) u_act_dly (
        .clk (clk), .en (adv), .din (item_reg.action), .dout (act_d)
    );

    always_comb
    begin
        case (act_d)
            ACT_MUL: sel_next = mul_d;
            ACT_DIV: sel_next = div_d;
            default: sel_next = pat_d;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pattern_reg  <= 64'(sel_next);
            error_reg    <= 64'(diff_d);
            mismatch_reg <= |diff_d;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {7'd0, error_reg, mismatch_reg, pattern_reg};

    a_mismatch_matches_bits: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[64] == (m_axis_tdata[128:65] != 64'd0)))
        else $error("mismatch flag disagrees with error bits");

    a_accept_enters_stage0: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> vld_reg[0])
        else $error("accepted request did not enter the pipeline");

    a_pattern_within_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[63:0] >> WORD_BITS) == 64'd0))
        else $error("pattern word has bits above the word width");

endmodule

FILE: test/testbench.sv
// Testbench for the memory test pattern unit: random and directed requests, checked results.
module testbench;
    import mtpu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        action_t     action;
        logic [8:0]  pass_number;
        logic [19:0] word_index;
        logic [63:0] word_address;
        logic [63:0] seed_word;
        logic [63:0] old_word;
        logic [63:0] read_a;
        logic [63:0] read_b;
    } request_t;

    typedef struct {
        logic [63:0] pattern_word;
        logic        mismatch;
        logic [63:0] error_bits;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_DATA_BITS-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;

    request_t pending_requests[$];
    outcome_t expected_outcomes[$];
    int       error_count;
    int       idle_cycles;
    int       send_idle_pct;
    int       recv_idle_pct;

    memory_test_pattern_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] bit_word(int pos);
        logic [63:0] w;
        w = '0;
        if (pos >= 0 && pos < 64)
            w[pos] = 1'b1;
        return w;
    endfunction

    function automatic logic [63:0] compute_pattern(request_t r);
        int          j;
        int          pos;
        logic [63:0] t;
        logic [63:0] q;
        j   = r.pass_number % 128;
        pos = (j < 64) ? j : 127 - j;
        q   = r.seed_word;
        case (r.action)
            ACT_STUCK:  return r.pass_number[0] ^ r.word_index[0] ? ~r.word_address
                                                                  : r.word_address;
            ACT_RANDOM: return q;
            ACT_XOR:    return r.old_word ^ q;
            ACT_SUB:    return r.old_word - q;
            ACT_MUL:    return r.old_word * q;
            ACT_DIV:    return r.old_word / ((q == 0) ? 64'd1 : q);
            ACT_OR:     return r.old_word | q;
            ACT_AND:    return r.old_word & q;
            ACT_SEQINC: return {44'd0, r.word_index} + q;
            ACT_SOLID:  t = r.pass_number[0] ? '0 : '1;
            ACT_CHECK:  t = r.pass_number[0] ? CHECK_ODD : CHECK_EVEN;
            ACT_BLOCK:  return {8{r.pass_number[7:0]}};
            ACT_WALK0:  return bit_word(pos);
            ACT_WALK1:  return ~bit_word(pos);
            ACT_SPREAD:
            begin
                if (j < 64)
                    t = bit_word(j) | bit_word(j + 2);
                else
                    t = bit_word(127 - j) | bit_word(129 - j);
                return r.word_index[0] ? ~t : t;
            end
            default:
            begin
                t = bit_word((r.pass_number >> 3) % 64);
                if (!r.pass_number[0])
                    t = ~t;
            end
        endcase
        return r.word_index[0] ? ~t : t;
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return {32'd0, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic request_t rand_request();
        request_t r;
        r.action       = action_t'($urandom_range(0, 15));
        r.pass_number  = 9'($urandom());
        r.word_index   = 20'($urandom());
        r.word_address = rand_word();
        r.seed_word    = rand_word();
        r.old_word     = rand_word();
        r.read_a       = rand_word();
        r.read_b       = $urandom_range(0, 1) ? r.read_a : r.read_a ^ rand_word();
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                request_t r;
                outcome_t o;
                r = pending_requests.pop_front();
                o.pattern_word = compute_pattern(r);
                o.error_bits   = r.read_a ^ r.read_b;
                o.mismatch     = |o.error_bits;
                expected_outcomes.push_back(o);
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'd0, r.read_b, r.read_a, r.old_word, r.seed_word,
                                  r.word_address, r.word_index, r.pass_number, r.action};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            idle_cycles   <= 0;
        end
        else
        begin
            m_axis_tready <= $urandom_range(0, 99) >= recv_idle_pct;
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    report_mismatch("unexpected result", m_axis_tdata[63:0], 64'd0);
                end
                else
                begin
                    outcome_t o;
                    o = expected_outcomes.pop_front();
                    if (m_axis_tdata[63:0] !== o.pattern_word)
                        report_mismatch("pattern_word", m_axis_tdata[63:0], o.pattern_word);
                    if (m_axis_tdata[64] !== o.mismatch)
                        report_mismatch("mismatch", 64'(m_axis_tdata[64]), 64'(o.mismatch));
                    if (m_axis_tdata[128:65] !== o.error_bits)
                        report_mismatch("error_bits", m_axis_tdata[128:65], o.error_bits);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        request_t r;
        error_count   = 0;
        send_idle_pct = 28;
        recv_idle_pct = 48;
        rst_n         = 1'b0;
        for (int a = 0; a < 16; a++)
        begin
            r = rand_request();
            r.action = action_t'(a);
            r.pass_number = (a % 2) ? 9'h1FF : 9'h0;
            r.word_index  = (a % 3) ? 20'hFFFFF : 20'h0;
            r.read_b = r.read_a;
            pending_requests.push_back(r);
        end
        r = rand_request();
        r.action = ACT_DIV;
        r.seed_word = '0;
        r.old_word = '1;
        pending_requests.push_back(r);
        r = rand_request();
        r.action = ACT_SPREAD;
        r.pass_number = 9'd63;
        pending_requests.push_back(r);
        r.pass_number = 9'd64;
        pending_requests.push_back(r);
        r.pass_number = 9'd127;
        r.read_a = '1;
        r.read_b = '0;
        pending_requests.push_back(r);
        r.action = ACT_SUB;
        r.old_word = '0;
        r.seed_word = 64'd1;
        pending_requests.push_back(r);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < 3; phase++)
        begin
            for (int n = 0; n < 650; n++)
                pending_requests.push_back(rand_request());
            while (pending_requests.size() > 0)
                @(posedge clk);
            if (phase == 0)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 28;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end
        while (s_axis_tvalid || expected_outcomes.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
